// ----- sv/rdwr_pkg.sv -----
// Shared types, constants and state encoding for the random draw block.
package rdwr_pkg;

    localparam int WORD_W       = 32;
    localparam int VAL_W        = 8;
    localparam int CNT_W        = 9;
    localparam int DEF_MAX_POOL = 256;

    localparam logic [CNT_W-1:0] POOL_SIZE_RESET = 9'd256;

    // Opcode values
    localparam logic OP_DRAW    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [WORD_W-1:0] random_word;
    } in_t;

    typedef struct packed {
        logic [VAL_W-1:0] picked_value;
        logic             pool_empty;
        logic [CNT_W-1:0] entries_left;
    } out_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_DIV,
        ST_RD_POS,
        ST_RD_LAST,
        ST_WR_POS,
        ST_WR_LAST,
        ST_DONE
    } state_t;

endpackage

// ----- sv/rdwr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rdwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/rdwr_divider.sv -----
// Restoring divider, one quotient bit per cycle; only the remainder is kept.
module rdwr_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [rdwr_pkg::WORD_W-1:0]  dividend,
    input  logic [rdwr_pkg::CNT_W-1:0]   divisor,
    output logic                         done,
    output logic [rdwr_pkg::CNT_W-1:0]   remainder
);

    import rdwr_pkg::*;

    localparam int STEP_W = $clog2(WORD_W);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic [WORD_W-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]  rem_reg,   rem_next;
    logic [CNT_W-1:0]  div_reg,   div_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg, shift_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (start) begin
            busy_next  = 1'b1;
            step_next  = '0;
            shift_next = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end else if (busy_reg) begin
            shift_next = {shift_reg[WORD_W-2:0], 1'b0};
            step_next  = step_reg + 1'b1;
            if (trial >= {1'b0, div_reg}) begin
                rem_next = diff[CNT_W-1:0];
            end else begin
                rem_next = trial[CNT_W-1:0];
            end
            if (step_reg == STEP_W'(WORD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- sv/random_draw_without_replacement.sv -----
// Top level: draw sequencer, pool store and result register.
//
//  channel   | direction | handshake           | payload
//  s_        | in        | s_valid / s_ready   | s_data   (opcode, random_word)
//  m_        | out       | m_valid / m_ready   | m_data   (picked_value, pool_empty,
//            |           |                     |           entries_left)
//  cfg_      | in        | cfg_valid/cfg_ready | cfg_data (pool_size)
//
// A draw runs the restoring divider (one bit per cycle of the 32-bit word), then the
// read-swap-write on the store (RD_POS, RD_LAST, WR_POS, WR_LAST), plus accept and
// result load. A draw on an empty pool skips the divider and the store.
// A restart, and the pass after reset, rewrite every store entry, one per cycle,
// with s_ready low. cfg_ready is always high.
// A held result stalls only the result load; the block waits in that step.
module random_draw_without_replacement #(
    parameter int MAX_POOL = rdwr_pkg::DEF_MAX_POOL
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  rdwr_pkg::in_t              s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output rdwr_pkg::out_t             m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [rdwr_pkg::CNT_W-1:0] cfg_data
);

    import rdwr_pkg::*;

    localparam int AW    = $clog2(MAX_POOL);
    localparam int EXT_W = (AW > CNT_W) ? AW : CNT_W;
    localparam logic [CNT_W-1:0] RESET_COUNT =
        (MAX_POOL < 256) ? CNT_W'(MAX_POOL) : POOL_SIZE_RESET;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  pool_size_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [AW-1:0]     fill_reg;
    logic              restart_reg;
    logic [AW-1:0]     pos_reg;
    logic [AW-1:0]     last_reg;
    logic [VAL_W-1:0]  hit_reg;
    logic [VAL_W-1:0]  picked_reg;
    logic              empty_reg;
    logic              m_valid_reg;
    out_t              m_data_reg;

    logic [CNT_W-1:0]  eff_size;
    logic [CNT_W-1:0]  count_dec;
    logic [EXT_W-1:0]  pos_ext;
    logic [EXT_W-1:0]  last_ext;
    logic              accept;
    logic              out_load;
    logic              fill_end;

    logic              div_start;
    logic              div_done;
    logic [CNT_W-1:0]  div_rem;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    // Count after a restart, saturated at the store depth
    assign eff_size  = (32'(pool_size_reg) > 32'(MAX_POOL)) ? CNT_W'(MAX_POOL)
                                                             : pool_size_reg;
    assign count_dec = count_reg - 1'b1;
    assign pos_ext   = EXT_W'(div_rem);
    assign last_ext  = EXT_W'(count_dec);

    assign accept    = s_valid && s_ready;
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign fill_end  = (fill_reg == AW'(MAX_POOL - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL: begin
                if (fill_end) begin
                    state_next = restart_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.opcode == OP_RESTART) begin
                        state_next = ST_FILL;
                    end else if (count_reg == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_RD_POS;
                end
            end
            ST_RD_POS:  state_next = ST_RD_LAST;
            ST_RD_LAST: state_next = ST_WR_POS;
            ST_WR_POS:  state_next = ST_WR_LAST;
            ST_WR_LAST: state_next = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Store, divider and handshake controls
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = fill_reg;
        ram_wdata = VAL_W'(fill_reg);
        ram_raddr = pos_reg;
        case (state_reg)
            ST_FILL: begin
                ram_we = 1'b1;
            end
            ST_IDLE: begin
                s_ready   = 1'b1;
                div_start = s_valid && (s_data.opcode == OP_DRAW) && (count_reg != '0);
            end
            ST_RD_POS: begin
                ram_raddr = pos_reg;
            end
            ST_RD_LAST: begin
                ram_raddr = last_reg;
            end
            ST_WR_POS: begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = ram_rdata;
            end
            ST_WR_LAST: begin
                ram_we    = 1'b1;
                ram_waddr = last_reg;
                ram_wdata = hit_reg;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sequencer state, pool count and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FILL;
            pool_size_reg <= POOL_SIZE_RESET;
            count_reg     <= RESET_COUNT;
            fill_reg      <= '0;
            restart_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                pool_size_reg <= cfg_data;
            end
            if (state_reg == ST_FILL) begin
                fill_reg <= fill_end ? '0 : fill_reg + 1'b1;
            end
            if (accept && (s_data.opcode == OP_RESTART)) begin
                count_reg   <= eff_size;
                restart_reg <= 1'b1;
            end else if (accept) begin
                restart_reg <= 1'b0;
            end
            if (state_reg == ST_WR_LAST) begin
                count_reg <= count_dec;
            end
            // Hold the result until taken; load the next one when free
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Draw datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            picked_reg <= '0;
            empty_reg  <= (s_data.opcode == OP_DRAW) && (count_reg == '0);
            last_reg   <= last_ext[AW-1:0];
        end
        if ((state_reg == ST_DIV) && div_done) begin
            pos_reg <= pos_ext[AW-1:0];
        end
        if (state_reg == ST_RD_LAST) begin
            hit_reg <= ram_rdata;
        end
        if (state_reg == ST_WR_LAST) begin
            picked_reg <= hit_reg;
        end
        if (out_load) begin
            m_data_reg.picked_value <= picked_reg;
            m_data_reg.pool_empty   <= empty_reg;
            m_data_reg.entries_left <= count_reg;
        end
    end

    rdwr_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (s_data.random_word),
        .divisor   (count_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    rdwr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_POOL)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // The live count never exceeds the store depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= 32'(MAX_POOL))
        else $error("pool count above store depth");

    // A division only runs on a non-empty pool
    a_div_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (count_reg != '0))
        else $error("divider running on empty pool");

    // The store is written only by the fill pass or the swap
    a_store_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_FILL || state_reg == ST_WR_POS
                    || state_reg == ST_WR_LAST))
        else $error("unexpected store write");

    // A swap lowers the count by one
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR_LAST) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("count not lowered after draw");

endmodule

// ----- test/tb.sv -----
// Testbench for the random draw block: shuffle predictor, stimulus and result checks.
`timescale 1ns / 1ps

module tb;

    typedef logic [rdwr_pkg::CNT_W-1:0] count_t;

    localparam count_t POOL_DEPTH = count_t'(rdwr_pkg::DEF_MAX_POOL);
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 300;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    rdwr_pkg::in_t              s_data;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    rdwr_pkg::out_t             m_data;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [rdwr_pkg::CNT_W-1:0] cfg_data;

    // Shadow of the pool: store, live count and pool size register
    logic [rdwr_pkg::VAL_W-1:0] pool_store [rdwr_pkg::DEF_MAX_POOL];
    logic [rdwr_pkg::CNT_W-1:0] live_count;
    logic [rdwr_pkg::CNT_W-1:0] pool_size_reg;

    rdwr_pkg::out_t pending_picks[$];
    rdwr_pkg::out_t head_pick;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int stall_cycles  = 0;
    int draws_sent    = 0;
    int empty_draws   = 0;
    int restarts_sent = 0;
    int size_writes   = 0;
    int picks_checked = 0;

    random_draw_without_replacement u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Refill the shadow store in identity order and reload the live count
    function automatic void refill_pool();
        for (int i = 0; i < rdwr_pkg::DEF_MAX_POOL; i++) begin
            pool_store[i] = i[rdwr_pkg::VAL_W-1:0];
        end
        live_count = (pool_size_reg > POOL_DEPTH) ? POOL_DEPTH : pool_size_reg;
    endfunction

    // Apply one item to the shadow pool and return the result it must produce
    function automatic rdwr_pkg::out_t shuffle_step(input rdwr_pkg::in_t item);
        rdwr_pkg::out_t             res;
        logic [31:0]                pos;
        logic [rdwr_pkg::CNT_W-1:0] last;
        logic [rdwr_pkg::VAL_W-1:0] hit;
        res = '0;
        if (item.opcode == rdwr_pkg::OP_RESTART) begin
            refill_pool();
        end else if (live_count == 0 || live_count > POOL_DEPTH) begin
            live_count = '0;
            res.pool_empty = 1'b1;
        end else begin
            pos  = item.random_word % {23'd0, live_count};
            last = live_count - 1'b1;
            hit  = pool_store[pos];
            if (pos < {23'd0, last}) begin
                pool_store[pos]  = pool_store[last];
                pool_store[last] = hit;
            end
            live_count = last;
            res.picked_value = hit;
        end
        res.entries_left = live_count;
        return res;
    endfunction

    // Present one item, hold it until the transfer, then record its result
    task automatic send_item(input logic op, input logic [31:0] word);
        rdwr_pkg::in_t item;
        item.opcode      = op;
        item.random_word = word;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (op == rdwr_pkg::OP_RESTART) begin
            restarts_sent++;
        end else begin
            draws_sent++;
            if (live_count == 0) empty_draws++;
        end
        pending_picks.push_back(shuffle_step(item));
    endtask

    // Stop sending and wait until every pending result has arrived
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge aclk);
    endtask

    task automatic write_pool_size(input logic [rdwr_pkg::CNT_W-1:0] size);
        @(negedge aclk);
        cfg_data  <= size;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        pool_size_reg = size;
        size_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly small pools so they run dry often; now and then the extremes
    function automatic logic [rdwr_pkg::CNT_W-1:0] pick_pool_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40) return count_t'($urandom_range(1, 16));
        if (roll < 65) return count_t'($urandom_range(17, 64));
        if (roll < 80) return count_t'($urandom_range(65, 255));
        if (roll < 88) return POOL_DEPTH;
        if (roll < 94) return '0;
        return count_t'($urandom_range(257, 511));
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom_range(511);
            default: return $urandom;
        endcase
    endfunction

    // Draws on the pool left by reset, with the extremes of the random word, then a restart and a draw
    task automatic test_reset_pool();
        send_item(rdwr_pkg::OP_DRAW, 32'h0000_0000);
        send_item(rdwr_pkg::OP_DRAW, 32'hFFFF_FFFF);
        send_item(rdwr_pkg::OP_DRAW, 32'd253);
        send_item(rdwr_pkg::OP_DRAW, 32'h8000_0000);
        send_item(rdwr_pkg::OP_RESTART, 32'hFFFF_FFFF);
        send_item(rdwr_pkg::OP_DRAW, 32'd255);
    endtask

    // Empty, single-entry, saturated and deferred pool sizes
    task automatic test_pool_size_extremes();
        drain_results();
        write_pool_size('0);
        send_item(rdwr_pkg::OP_RESTART, 32'd0);
        send_item(rdwr_pkg::OP_DRAW, 32'hFFFF_FFFF);
        send_item(rdwr_pkg::OP_DRAW, 32'd0);
        drain_results();
        write_pool_size(9'd1);
        send_item(rdwr_pkg::OP_RESTART, 32'd0);
        send_item(rdwr_pkg::OP_DRAW, 32'hFFFF_FFFF);
        send_item(rdwr_pkg::OP_DRAW, 32'd7);
        drain_results();
        write_pool_size(9'd511);
        send_item(rdwr_pkg::OP_RESTART, 32'd0);
        send_item(rdwr_pkg::OP_DRAW, 32'd255);
        drain_results();
        write_pool_size(9'd257);
        send_item(rdwr_pkg::OP_RESTART, 32'd0);
        send_item(rdwr_pkg::OP_DRAW, 32'hFFFF_FFFF);
        // A new size must not touch the live pool until the next restart
        drain_results();
        write_pool_size(9'd2);
        send_item(rdwr_pkg::OP_DRAW, 32'd1);
        send_item(rdwr_pkg::OP_RESTART, 32'd0);
        send_item(rdwr_pkg::OP_DRAW, 32'd1);
        send_item(rdwr_pkg::OP_DRAW, 32'd1);
        send_item(rdwr_pkg::OP_DRAW, 32'd1);
    endtask

    // Segments of one pool size each: restart, draws with random restarts, up to three empty draws when dry
    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int item_count);
        int sent;
        int seg_len;
        int empty_budget;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        sent = 0;
        while (sent < item_count) begin
            drain_results();
            write_pool_size(pick_pool_size());
            send_item(rdwr_pkg::OP_RESTART, $urandom);
            sent++;
            seg_len = $urandom_range(60, 140);
            empty_budget = $urandom_range(0, 3);
            for (int k = 0; k < seg_len && sent < item_count; k++) begin
                if ($urandom_range(99) < 3 || (live_count == 0 && empty_budget == 0)) begin
                    send_item(rdwr_pkg::OP_RESTART, $urandom);
                    empty_budget = $urandom_range(0, 3);
                end else begin
                    if (live_count == 0) empty_budget--;
                    send_item(rdwr_pkg::OP_DRAW, pick_word());
                end
                sent++;
            end
        end
    endtask

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each result transfer with the oldest pending result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_picks.size() == 0) begin
                $error("result with no draw pending: picked_value %0d pool_empty %0d entries_left %0d",
                       m_data.picked_value, m_data.pool_empty, m_data.entries_left);
                error_count++;
            end else begin
                head_pick = pending_picks.pop_front();
                picks_checked++;
                if (m_data.picked_value !== head_pick.picked_value) begin
                    $error("picked_value: expected %0d, got %0d",
                           head_pick.picked_value, m_data.picked_value);
                    error_count++;
                end
                if (m_data.pool_empty !== head_pick.pool_empty) begin
                    $error("pool_empty: expected %0d, got %0d",
                           head_pick.pool_empty, m_data.pool_empty);
                    error_count++;
                end
                if (m_data.entries_left !== head_pick.entries_left) begin
                    $error("entries_left: expected %0d, got %0d",
                           head_pick.entries_left, m_data.entries_left);
                    error_count++;
                end
            end
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles, %0d results still pending",
                         STALL_LIMIT, pending_picks.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        pool_size_reg = rdwr_pkg::POOL_SIZE_RESET;
        refill_pool();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_pool();
        test_pool_size_extremes();
        test_random_traffic(16, 87, 630);
        test_random_traffic(87, 16, 630);
        test_random_traffic(0, 0, 630);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d draws (%0d on an empty pool), %0d restarts, %0d pool size writes",
                 draws_sent, empty_draws, restarts_sent, size_writes);
        $display("Checked %0d results under three sender/receiver idling mixes", picks_checked);
        if (error_count == 0 && pending_picks.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (pending_picks.size() != 0) begin
                $error("%0d results never arrived", pending_picks.size());
            end
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
